@@ rtl/a64rel_pkg.sv @@
// ============================================================================
// a64rel_pkg
// Shared types and constants for the AArch64 PC-relative relocator.
// ============================================================================
package a64rel_pkg;

    localparam int MAX_RUN_DEF = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int INSN_W     = 32;
    localparam int POS_W      = 5;
    localparam int OUT_DATA_W = 48;
    localparam int IN_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAVE_BASE = 1'b1;

    typedef enum logic [2:0] {
        F_OTHER  = 3'd0,
        F_ADR    = 3'd1,
        F_ADRP   = 3'd2,
        F_B      = 3'd3,
        F_BCOND  = 3'd4,
        F_CBZ    = 3'd5,
        F_TBZ    = 3'd6,
        F_LDRLIT = 3'd7
    } form_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SKIP  = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    // decode masks and match values
    localparam logic [31:0] ADR_MASK    = 32'h1F00_0000;
    localparam logic [31:0] ADR_MATCH   = 32'h1000_0000;
    localparam logic [31:0] B_MASK      = 32'h7C00_0000;
    localparam logic [31:0] B_MATCH     = 32'h1400_0000;
    localparam logic [31:0] BCOND_MASK  = 32'hFF00_0010;
    localparam logic [31:0] BCOND_MATCH = 32'h5400_0000;
    localparam logic [31:0] CB_MASK     = 32'h7E00_0000;
    localparam logic [31:0] CBZ_MATCH   = 32'h3400_0000;
    localparam logic [31:0] TBZ_MATCH   = 32'h3600_0000;
    localparam logic [31:0] LDR_MASK    = 32'h3B00_0000;
    localparam logic [31:0] LDR_MATCH   = 32'h1800_0000;

    // bits kept when re-encoding
    localparam logic [31:0] KEEP_ADR = 32'h9F00_001F;
    localparam logic [31:0] KEEP_B   = 32'hFC00_0000;
    localparam logic [31:0] KEEP_19  = 32'hFF00_001F;
    localparam logic [31:0] KEEP_TBZ = 32'hFFF8_001F;

    function automatic form_t decode_form(input logic [31:0] insn);
        form_t f;
        f = F_OTHER;
        if ((insn & ADR_MASK) == ADR_MATCH)
            f = insn[31] ? F_ADRP : F_ADR;
        else if ((insn & B_MASK) == B_MATCH)
            f = F_B;
        else if ((insn & BCOND_MASK) == BCOND_MATCH)
            f = F_BCOND;
        else if ((insn & CB_MASK) == CBZ_MATCH)
            f = F_CBZ;
        else if ((insn & CB_MASK) == TBZ_MATCH)
            f = F_TBZ;
        else if ((insn & LDR_MASK) == LDR_MATCH)
            f = F_LDRLIT;
        return f;
    endfunction

endpackage

@@ rtl/arm64_pc_relative_relocator.sv @@
// ============================================================================
// arm64_pc_relative_relocator
// Rewrites PC-relative AArch64 instruction words for a move to a new base.
// ============================================================================
//
//  channel   dir  handshake         contents
//  --------  ---  ----------------  -----------------------------------------
//  s_*       in   tvalid/tready     tdata = insn_in, tlast = last_in
//  m_*       out  tvalid/tready     tdata = insn_out/form/status/position,
//                                   tlast = last_out
//  cfg_*     in   cfg_we            index 0 orig_base, index 1 cave_base
//
//  One word per cycle; each word passes the input register, then the result
//  register. The offset add and range check sit between the two. Run state
//  advances when a word moves into the result register. A stall on m_tready
//  holds both stages; s_tready drops only when both are full. Reset clears
//  valids and run state; the base registers reset to zero.
//
module arm64_pc_relative_relocator #(
    parameter int MAX_RUN = a64rel_pkg::MAX_RUN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [a64rel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [a64rel_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [a64rel_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] insn_in
    input  logic                               s_tlast,   // last_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] insn_out, [34:32] form, [36:35] status, [41:37] position, rest 0
    output logic [a64rel_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                               m_tlast    // last_out
);
    import a64rel_pkg::*;

    localparam int IDX_W = $clog2(MAX_RUN + 1);

    // configuration and precomputed distances
    logic [63:0] orig_base_reg;
    logic [63:0] cave_base_reg;
    logic [63:0] delta_reg;     // orig_base - cave_base
    logic [51:0] pdelta_reg;    // page number difference

    // input stage
    logic        s1_valid_reg;
    logic [31:0] s1_insn_reg;
    logic        s1_last_reg;

    // run state
    logic [IDX_W-1:0] run_index_reg, run_index_next;
    logic             run_failed_reg, run_failed_next;

    // result stage
    logic        out_valid_reg;
    logic [31:0] out_insn_reg;
    form_t       out_form_reg;
    status_t     out_status_reg;
    logic [4:0]  out_pos_reg;
    logic        out_last_reg;

    logic s1_move;
    logic s_xfer;

    form_t       form;
    status_t     res_status;
    logic [31:0] res_insn;
    logic [4:0]  res_pos;
    logic [5:0]  idx_ext;

    logic [20:0] adr_imm;
    logic [63:0] adr_v;
    logic [12:0] opc_low, cpc_low;
    logic [51:0] adrp_v;
    logic [61:0] br_imm;
    logic [61:0] br_s;
    logic [61:0] br_q;
    logic        fit_ok;
    logic [31:0] enc_insn;

    assign s1_move  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_xfer   = s_tvalid && s_tready;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_base_reg <= '0;
            cave_base_reg <= '0;
            delta_reg     <= '0;
            pdelta_reg    <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ORIG_BASE)
            begin
                orig_base_reg <= cfg_data;
                delta_reg     <= cfg_data - cave_base_reg;
                pdelta_reg    <= cfg_data[63:12] - cave_base_reg[63:12];
            end
            else
            begin
                cave_base_reg <= cfg_data;
                delta_reg     <= orig_base_reg - cfg_data;
                pdelta_reg    <= orig_base_reg[63:12] - cfg_data[63:12];
            end
        end
    end

    // ----------------------------------------------------------- input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            s1_insn_reg <= s_tdata[31:0];
            s1_last_reg <= s_tlast;
        end
    end

    // ---------------------------------------------------------- relocation
    always_comb
    begin
        form    = decode_form(s1_insn_reg);
        idx_ext = 6'(run_index_reg);
        res_pos = idx_ext[5] ? 5'd31 : idx_ext[4:0];

        // ADR: byte distance; ADRP: page distance with page carries of each PC
        adr_imm = {s1_insn_reg[23:5], s1_insn_reg[30:29]};
        adr_v   = delta_reg + {{43{adr_imm[20]}}, adr_imm};
        opc_low = {1'b0, orig_base_reg[11:0]} + 13'({run_index_reg, 2'b00});
        cpc_low = {1'b0, cave_base_reg[11:0]} + 13'({run_index_reg, 2'b00});
        adrp_v  = pdelta_reg + {{31{adr_imm[20]}}, adr_imm}
                + 52'(opc_low[12]) - 52'(cpc_low[12]);

        // scaled forms: word distance, rounded toward zero
        case (form)
            F_B:     br_imm = {{36{s1_insn_reg[25]}}, s1_insn_reg[25:0]};
            F_TBZ:   br_imm = {{48{s1_insn_reg[18]}}, s1_insn_reg[18:5]};
            default: br_imm = {{43{s1_insn_reg[23]}}, s1_insn_reg[23:5]};
        endcase
        br_s = delta_reg[63:2] + br_imm;
        br_q = br_s + 62'(br_s[61] && (delta_reg[1:0] != 2'b00));

        fit_ok   = 1'b1;
        enc_insn = s1_insn_reg;
        case (form)
            F_ADR:
            begin
                fit_ok   = (&adr_v[63:20]) || !(|adr_v[63:20]);
                enc_insn = (s1_insn_reg & KEEP_ADR) | {1'b0, adr_v[1:0], 5'd0,
                           adr_v[20:2], 5'd0};
            end
            F_ADRP:
            begin
                fit_ok   = (&adrp_v[51:20]) || !(|adrp_v[51:20]);
                enc_insn = (s1_insn_reg & KEEP_ADR) | {1'b0, adrp_v[1:0], 5'd0,
                           adrp_v[20:2], 5'd0};
            end
            F_B:
            begin
                fit_ok   = (&br_q[61:25]) || !(|br_q[61:25]);
                enc_insn = (s1_insn_reg & KEEP_B) | {6'd0, br_q[25:0]};
            end
            F_BCOND, F_CBZ, F_LDRLIT:
            begin
                fit_ok   = (&br_q[61:18]) || !(|br_q[61:18]);
                enc_insn = (s1_insn_reg & KEEP_19) | {8'd0, br_q[18:0], 5'd0};
            end
            F_TBZ:
            begin
                fit_ok   = (&br_q[61:13]) || !(|br_q[61:13]);
                enc_insn = (s1_insn_reg & KEEP_TBZ) | {13'd0, br_q[13:0], 5'd0};
            end
            default:
            begin
                fit_ok   = 1'b1;
                enc_insn = s1_insn_reg;
            end
        endcase

        res_insn        = s1_insn_reg;
        res_status      = ST_OK;
        run_failed_next = run_failed_reg;
        if (run_failed_reg)
            res_status = ST_SKIP;
        else if (run_index_reg >= IDX_W'(MAX_RUN))
            res_status = ST_LONG;
        else if (fit_ok)
            res_insn = enc_insn;
        else
        begin
            res_status      = ST_RANGE;
            run_failed_next = 1'b1;
        end

        run_index_next = run_index_reg;
        if (s1_last_reg)
        begin
            run_index_next  = '0;
            run_failed_next = 1'b0;
        end
        else if (run_index_reg < IDX_W'(MAX_RUN))
            run_index_next = run_index_reg + IDX_W'(1);
    end

    // ---------------------------------------------------------- run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_index_reg  <= '0;
            run_failed_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_move)
        begin
            run_index_reg  <= run_index_next;
            run_failed_reg <= run_failed_next;
        end
    end

    // ---------------------------------------------------------- result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_move)
        begin
            out_insn_reg   <= res_insn;
            out_form_reg   <= form;
            out_status_reg <= res_status;
            out_pos_reg    <= res_pos;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_pos_reg, out_status_reg, out_form_reg, out_insn_reg};

    // ---------------------------------------------------------- assertions
    a_fail_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_move && res_status == ST_RANGE && !s1_last_reg)
        |=> run_failed_reg)
        else $error("out-of-range word did not mark the run failed");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_move && s1_last_reg)
        |=> (run_index_reg == '0 && !run_failed_reg))
        else $error("run state not cleared after last word");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_index_reg <= IDX_W'(MAX_RUN))
        else $error("run index beyond bound");

    a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_move && (form == F_OTHER || res_status != ST_OK))
        |=> (m_tdata[31:0] == $past(s1_insn_reg)))
        else $error("unchanged word was altered");

endmodule
